@@ sv/rtcct_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtcct_pkg: shared types and constants of the RTC compare timer
// Transfer payloads, the operation codes and the per-channel command and
// status groups.
// ----------------------------------------------------------------------------
package rtcct_pkg;

    localparam int DELAY_BITS = 24;
    localparam int WRAP_BITS  = 32;
    localparam int TIME_BITS  = 56;
    localparam int PEND_BITS  = 3;
    // Overflow extension plus widest counter fits in this many bits
    localparam int EXT_MAX_BITS = 64;

    typedef enum logic [2:0] {
        OP_TICK      = 3'd0,
        OP_ARM       = 3'd1,
        OP_CANCEL    = 3'd2,
        OP_ACK_CHAN  = 3'd3,
        OP_ACK_OVF   = 3'd4,
        OP_READ_TIME = 3'd5,
        OP_CLEAR     = 3'd6,
        OP_START     = 3'd7
    } t_opcode;

    typedef struct packed {
        t_opcode                 opcode;
        logic                    channel;
        logic [DELAY_BITS-1:0]   delay_ticks;
    } t_in_item;

    typedef struct packed {
        logic [TIME_BITS-1:0]    time_now;
        logic [PEND_BITS-1:0]    pending_events;
        logic                    irq;
    } t_out_item;

    // Commands to one compare channel, already qualified by the executing item
    typedef struct packed {
        logic tick;     // running counter advances this cycle
        logic arm;
        logic cancel;
        logic ack;
    } t_chan_cmd;

    // Post-update status of one compare channel
    typedef struct packed {
        logic flag;
        logic irq_en;
    } t_chan_stat;

endpackage

@@ sv/rtcct_channel.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtcct_channel: one compare channel
// Holds the compare value, the event flag and the two enables, and reports
// the status that results from the current command.
// ----------------------------------------------------------------------------
module rtcct_channel #(
    parameter int COUNT_BITS = 24
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  rtcct_pkg::t_chan_cmd      i_cmd,
    input  logic [COUNT_BITS-1:0]     i_tick_next,
    input  logic [COUNT_BITS-1:0]     i_arm_value,
    output rtcct_pkg::t_chan_stat     o_stat
);

    logic [COUNT_BITS-1:0] r_cmp, n_cmp;
    logic                  r_flag, n_flag;
    logic                  r_ev_en, n_ev_en;
    logic                  r_irq_en, n_irq_en;

    always_comb begin
        n_cmp    = r_cmp;
        n_flag   = r_flag;
        n_ev_en  = r_ev_en;
        n_irq_en = r_irq_en;
        priority if (i_cmd.arm) begin
            n_cmp    = i_arm_value;
            n_flag   = 1'b0;
            n_ev_en  = 1'b1;
            n_irq_en = 1'b1;
        end else if (i_cmd.cancel || (i_cmd.ack && r_irq_en && r_flag)) begin
            n_flag   = 1'b0;
            n_ev_en  = 1'b0;
            n_irq_en = 1'b0;
        end else if (i_cmd.tick && (r_ev_en || r_irq_en) && (r_cmp == i_tick_next)) begin
            n_flag   = 1'b1;
        end else begin
            n_flag   = r_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag   <= 1'b0;
            r_ev_en  <= 1'b0;
            r_irq_en <= 1'b0;
        end else begin
            r_flag   <= n_flag;
            r_ev_en  <= n_ev_en;
            r_irq_en <= n_irq_en;
        end
    end

    // Compare value only matters once armed
    always_ff @(posedge i_clk) begin
        r_cmp <= n_cmp;
    end

    assign o_stat.flag   = n_flag;
    assign o_stat.irq_en = n_irq_en;

endmodule

@@ sv/rtc_compare_timer_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_compare_timer_core: real-time counter with compare channels
// Tick counter with a 32-bit overflow extension, compare channels and an
// overflow event; every operation returns the extended time and events.
// ----------------------------------------------------------------------------
//
//  channel  | valid        | stall        | payload
//  ---------+--------------+--------------+-------------------------------
//  input    | i_in_valid   | o_in_stall   | i_in_data  (t_in_item)
//  output   | o_out_valid  | i_out_stall  | o_out_data (t_out_item)
//
//  Each operation's result is offered from the result register: the item
//  waits in the input register, and the edge at which it fires updates
//  the state and loads the result register.
//  One operation completes per cycle unless the result stalls; the state
//  update of one item is seen by the next, since both land at the same edge.
//  Reset (synchronous, active low) stops the counter and clears all events,
//  enables, the counter and the extension.
//  A stalled result holds the input register; the input stalls only while
//  its register is full and cannot advance.
//
module rtc_compare_timer_core #(
    parameter int COUNT_BITS   = 24,
    parameter int NUM_CHANNELS = 2
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  rtcct_pkg::t_in_item    i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output rtcct_pkg::t_out_item   o_out_data
);

    localparam int EXT_BITS = COUNT_BITS + rtcct_pkg::WRAP_BITS;

    // Input register
    logic                  r_s1_valid;
    rtcct_pkg::t_in_item   r_s1;

    // Result register
    logic                  r_out_valid;
    rtcct_pkg::t_out_item  r_out, n_out;

    // Counter state
    logic [COUNT_BITS-1:0]           r_tick, n_tick;
    logic [rtcct_pkg::WRAP_BITS-1:0] r_wrap, n_wrap;
    logic                            r_ovf_flag, n_ovf_flag;
    logic                            r_ovf_irq_en, n_ovf_irq_en;
    logic                            r_running, n_running;

    logic                  w_adv;
    logic                  w_fire;
    logic                  w_in_xfer;
    logic                  w_tick_go;
    logic [COUNT_BITS-1:0] w_tick_inc;
    logic [COUNT_BITS-1:0] w_arm_value;
    logic [EXT_BITS-1:0]   w_ext_time;
    logic [rtcct_pkg::EXT_MAX_BITS-1:0] w_time_full;
    logic [NUM_CHANNELS-1:0] w_flags;
    logic [NUM_CHANNELS-1:0] w_irq_ens;
    logic                  w_pend_c1;

    // ---- handshake ---------------------------------------------------------
    // Advance the input register when the result register is free or draining
    assign w_adv      = !r_out_valid || !i_out_stall;
    assign w_fire     = r_s1_valid && w_adv;
    assign o_in_stall = r_s1_valid && !w_adv;
    assign w_in_xfer  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_xfer) begin
                r_s1_valid <= 1'b1;
            end else if (w_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_s1 <= i_in_data;
        end
        if (w_fire) begin
            r_out <= n_out;
        end
    end

    // ---- counter and overflow ----------------------------------------------
    assign w_tick_go   = w_fire && (r_s1.opcode == rtcct_pkg::OP_TICK) && r_running;
    assign w_tick_inc  = r_tick + COUNT_BITS'(1);
    // Compare target wraps modulo the counter width
    assign w_arm_value = r_tick + COUNT_BITS'(r_s1.delay_ticks);

    always_comb begin
        n_tick       = r_tick;
        n_wrap       = r_wrap;
        n_ovf_flag   = r_ovf_flag;
        n_ovf_irq_en = r_ovf_irq_en;
        n_running    = r_running;
        if (w_fire) begin
            unique case (r_s1.opcode)
                rtcct_pkg::OP_TICK: begin
                    if (r_running) begin
                        n_tick = w_tick_inc;
                        // Count the wrap into the extension
                        if (w_tick_inc == '0) begin
                            n_ovf_flag = 1'b1;
                            n_wrap     = r_wrap + rtcct_pkg::WRAP_BITS'(1);
                        end
                    end
                end
                rtcct_pkg::OP_ACK_OVF: begin
                    n_ovf_flag = 1'b0;
                end
                rtcct_pkg::OP_CLEAR: begin
                    n_tick = '0;
                end
                rtcct_pkg::OP_START: begin
                    n_running    = 1'b1;
                    n_ovf_irq_en = 1'b1;
                end
                rtcct_pkg::OP_ARM,
                rtcct_pkg::OP_CANCEL,
                rtcct_pkg::OP_ACK_CHAN,
                rtcct_pkg::OP_READ_TIME: begin
                    n_running = r_running;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick       <= '0;
            r_wrap       <= '0;
            r_ovf_flag   <= 1'b0;
            r_ovf_irq_en <= 1'b0;
            r_running    <= 1'b0;
        end else begin
            r_tick       <= n_tick;
            r_wrap       <= n_wrap;
            r_ovf_flag   <= n_ovf_flag;
            r_ovf_irq_en <= n_ovf_irq_en;
            r_running    <= n_running;
        end
    end

    // ---- compare channels --------------------------------------------------
    for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_chan
        logic                  w_sel;
        rtcct_pkg::t_chan_cmd  w_cmd;
        rtcct_pkg::t_chan_stat w_stat;

        // Channels beyond the field's reach are never selected
        assign w_sel = ({31'd0, r_s1.channel} == 32'(g));

        assign w_cmd.tick   = w_tick_go;
        assign w_cmd.arm    = w_fire && w_sel && (r_s1.opcode == rtcct_pkg::OP_ARM);
        assign w_cmd.cancel = w_fire && w_sel && (r_s1.opcode == rtcct_pkg::OP_CANCEL);
        assign w_cmd.ack    = w_fire && w_sel && (r_s1.opcode == rtcct_pkg::OP_ACK_CHAN);

        rtcct_channel #(
            .COUNT_BITS (COUNT_BITS)
        ) u_chan (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (w_cmd),
            .i_tick_next (w_tick_inc),
            .i_arm_value (w_arm_value),
            .o_stat      (w_stat)
        );

        assign w_flags[g]   = w_stat.flag;
        assign w_irq_ens[g] = w_stat.irq_en;
    end

    if (NUM_CHANNELS > 1) begin : g_pend_c1
        assign w_pend_c1 = w_flags[1];
    end else begin : g_no_c1
        assign w_pend_c1 = 1'b0;
    end

    // ---- result ------------------------------------------------------------
    // Extension sits directly above the counter; keep the low time bits
    assign w_ext_time  = {n_wrap, n_tick};
    assign w_time_full = rtcct_pkg::EXT_MAX_BITS'(w_ext_time);

    always_comb begin
        n_out.time_now       = w_time_full[rtcct_pkg::TIME_BITS-1:0];
        n_out.pending_events = {n_ovf_flag, w_pend_c1, w_flags[0]};
        n_out.irq            = (|(w_flags & w_irq_ens)) || (n_ovf_flag && n_ovf_irq_en);
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTH
    a_wrap_sets_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_tick_go && (r_tick == '1)) |=> (r_ovf_flag && (r_tick == '0)))
        else $error("counter wrap did not raise the overflow event");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && r_out_valid))
        else $error("input stalled with room to advance");

    a_fire_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> o_out_valid)
        else $error("executed item produced no result");

    a_running_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_running |=> r_running)
        else $error("counter stopped without reset");

    a_clear_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && (r_s1.opcode == rtcct_pkg::OP_CLEAR)) |=> (r_tick == '0))
        else $error("clear left the counter non-zero");
`endif

endmodule

@@ dv/rtc_compare_timer_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_compare_timer_core_test: self-checking bench for the RTC compare timer
// Drives operations through the valid/stall input channel and predicts
// each report of time, pending events and interrupt with a cycle-free model
// of the counter. Every report on the output channel is checked against the
// oldest prediction. Both channels idle at random. A long receiver hold-off
// fills the pipeline.
// ----------------------------------------------------------------------------
module rtc_compare_timer_core_test;

    localparam int CNT_W       = 24;
    localparam int N_CHAN      = 2;
    localparam int OVF_IDX     = N_CHAN;   // overflow uses the bit above the channels
    localparam int LONG_HOLD   = 80;       // receiver hold-off for the pressure test
    localparam int IDLE_LIMIT  = 2000;     // cycles without any transfer before giving up
    localparam int RANDOM_OPS  = 1600;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    rtcct_pkg::t_in_item   i_in_data   = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b1;
    rtcct_pkg::t_out_item  o_out_data;

    // Predicted state of the counter, mirrored per accepted transfer
    logic [CNT_W-1:0]                m_ticks   = '0;
    logic [rtcct_pkg::WRAP_BITS-1:0] m_wraps   = '0;
    logic [CNT_W-1:0]                m_cmp [N_CHAN];
    logic [2:0]                      m_flags   = '0;
    logic [2:0]                      m_irq_en  = '0;
    logic [2:0]                      m_evt_en  = '0;
    logic                            m_running = 1'b0;

    rtcct_pkg::t_out_item  reports_due[$];     // predicted reports, oldest first
    int         bad_reports   = 0;
    int         reports_seen  = 0;
    int         items_sent    = 0;
    int         idle_cycles   = 0;
    bit         no_idle       = 1'b0;   // both sides run without gaps while set
    bit         long_hold_req = 1'b0;

    initial begin
        m_cmp[0] = '0;
        m_cmp[1] = '0;
    end

    rtc_compare_timer_core #(
        .COUNT_BITS   (CNT_W),
        .NUM_CHANNELS (N_CHAN)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // 12 ns period
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Random helpers sized to the fields they feed
    function automatic logic [CNT_W-1:0] rand_dly(input int unsigned hi);
        return CNT_W'($urandom_range(0, hi));
    endfunction

    function automatic logic rand_ch();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic rtcct_pkg::t_opcode rand_op();
        return rtcct_pkg::t_opcode'(3'($urandom_range(0, 7)));
    endfunction

    // ------------------------------------------------------------------------
    // Predictor: apply one operation to the mirrored state and return the
    // report it produces, taken after the update.
    // ------------------------------------------------------------------------
    function automatic rtcct_pkg::t_out_item advance_rtc(rtcct_pkg::t_in_item op_item);
        rtcct_pkg::t_out_item  rep;
        logic [2:0] sel;
        sel = 3'b001 << op_item.channel;
        case (op_item.opcode)
            rtcct_pkg::OP_TICK: begin
                // Hold the counter while stopped
                if (m_running) begin
                    m_ticks = m_ticks + CNT_W'(1);
                    // A wrap sets the overflow event and counts into the extension
                    if (m_ticks == '0) begin
                        m_flags[OVF_IDX] = 1'b1;
                        m_wraps          = m_wraps + rtcct_pkg::WRAP_BITS'(1);
                    end
                    for (int c = 0; c < N_CHAN; c++) begin
                        if ((m_evt_en[c] || m_irq_en[c]) && m_cmp[c] == m_ticks)
                            m_flags[c] = 1'b1;
                    end
                end
            end
            rtcct_pkg::OP_ARM: begin
                // Zero delay lands on the current count, so it matches after a full wrap
                m_cmp[op_item.channel] = m_ticks + op_item.delay_ticks;
                m_flags  = m_flags & ~sel;
                m_evt_en = m_evt_en | sel;
                m_irq_en = m_irq_en | sel;
            end
            rtcct_pkg::OP_CANCEL: begin
                m_flags  = m_flags & ~sel;
                m_evt_en = m_evt_en & ~sel;
                m_irq_en = m_irq_en & ~sel;
            end
            rtcct_pkg::OP_ACK_CHAN: begin
                // Only a pending event with its interrupt enabled is acknowledged
                if ((m_irq_en & sel) != '0 && (m_flags & sel) != '0) begin
                    m_flags  = m_flags & ~sel;
                    m_evt_en = m_evt_en & ~sel;
                    m_irq_en = m_irq_en & ~sel;
                end
            end
            rtcct_pkg::OP_ACK_OVF: m_flags[OVF_IDX] = 1'b0;
            rtcct_pkg::OP_READ_TIME: ;
            rtcct_pkg::OP_CLEAR: m_ticks = '0;
            rtcct_pkg::OP_START: begin
                m_evt_en[OVF_IDX] = 1'b1;
                m_irq_en[OVF_IDX] = 1'b1;
                m_running         = 1'b1;
            end
            default: ;
        endcase
        rep.time_now       = {m_wraps, m_ticks};
        rep.pending_events = m_flags;
        rep.irq            = |(m_flags & m_irq_en);
        return rep;
    endfunction

    // ------------------------------------------------------------------------
    // Offer one operation after a random gap and hold it until transferred;
    // the prediction is queued at the transfer edge.
    // ------------------------------------------------------------------------
    task automatic send_op(input rtcct_pkg::t_opcode op, input logic ch,
                           input logic [CNT_W-1:0] dly);
        int unsigned         gap;
        rtcct_pkg::t_in_item op_item;
        op_item.opcode      = op;
        op_item.channel     = ch;
        op_item.delay_ticks = dly;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= op_item;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        reports_due.push_back(advance_rtc(op_item));
        items_sent++;
    endtask

    // Pause the sender until every predicted report has come back
    task automatic drain_reports();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (reports_due.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Counter stopped after reset: ticks do nothing, bus writes still land
    task automatic test_stopped_counter();
        send_op(rtcct_pkg::OP_READ_TIME, 1'b0, '0);
        send_op(rtcct_pkg::OP_TICK,      1'b1, 24'hFFFFFF);
        send_op(rtcct_pkg::OP_TICK,      1'b0, '0);
        send_op(rtcct_pkg::OP_ARM,       1'b0, 24'd5);
        send_op(rtcct_pkg::OP_ACK_OVF,   1'b1, '0);
        send_op(rtcct_pkg::OP_CLEAR,     1'b0, '0);
    endtask

    // Start, run up to a compare match, then acknowledge it twice
    task automatic test_compare_match();
        send_op(rtcct_pkg::OP_START, 1'b0, '0);
        repeat (5) send_op(rtcct_pkg::OP_TICK, 1'b0, '0);
        send_op(rtcct_pkg::OP_ACK_CHAN, 1'b0, '0);
        send_op(rtcct_pkg::OP_ACK_CHAN, 1'b0, '0);     // nothing left to acknowledge
    endtask

    // Cancel a live match, then arm with the widest and zero delays
    task automatic test_cancel_and_delays();
        send_op(rtcct_pkg::OP_ARM,       1'b1, 24'd2);
        send_op(rtcct_pkg::OP_TICK,      1'b1, '0);
        send_op(rtcct_pkg::OP_TICK,      1'b1, '0);
        send_op(rtcct_pkg::OP_CANCEL,    1'b1, '0);
        send_op(rtcct_pkg::OP_ARM,       1'b1, 24'hFFFFFF);
        send_op(rtcct_pkg::OP_ARM,       1'b0, '0);
        send_op(rtcct_pkg::OP_TICK,      1'b0, 24'h555555);
        send_op(rtcct_pkg::OP_ACK_CHAN,  1'b1, 24'hAAAAAA);   // armed but no event: ignored
        send_op(rtcct_pkg::OP_CLEAR,     1'b1, '0);
        send_op(rtcct_pkg::OP_READ_TIME, 1'b1, 24'hFFFFFF);
    endtask

    // Mostly arm/tick/acknowledge sequences with random content, some noise.
    // A counter wrap needs 2^24 ticks and is out of reach at this width.
    task automatic test_random_sequences(input int target);
        int unsigned kind;
        int unsigned n;
        logic        ch;
        while (items_sent < target) begin
            if ($urandom_range(0, 15) == 0)
                no_idle = !no_idle;
            kind = $urandom_range(0, 9);
            ch   = rand_ch();
            if (kind <= 6) begin
                if ($urandom_range(0, 7) == 0)
                    send_op(rtcct_pkg::OP_ARM, ch, rand_dly(24'hFFFFFF));
                else
                    send_op(rtcct_pkg::OP_ARM, ch, rand_dly(24));
                n = $urandom_range(0, 30);
                repeat (n) begin
                    if ($urandom_range(0, 5) == 0)
                        send_op(rtcct_pkg::OP_READ_TIME, rand_ch(), rand_dly(24'hFFFFFF));
                    else
                        send_op(rtcct_pkg::OP_TICK, rand_ch(), rand_dly(24'hFFFFFF));
                end
                case ($urandom_range(0, 3))
                    0, 1: send_op(rtcct_pkg::OP_ACK_CHAN, ch, rand_dly(24'hFFFFFF));
                    2:    send_op(rtcct_pkg::OP_CANCEL,   ch, rand_dly(24'hFFFFFF));
                    default: send_op(rtcct_pkg::OP_ACK_CHAN, !ch, rand_dly(24'hFFFFFF));
                endcase
                if ($urandom_range(0, 3) == 0)
                    send_op(rtcct_pkg::OP_ACK_OVF, rand_ch(), rand_dly(24'hFFFFFF));
            end else if (kind <= 8) begin
                // Noise: any operation with any fields
                n = $urandom_range(1, 6);
                repeat (n)
                    send_op(rand_op(), rand_ch(), rand_dly(24'hFFFFFF));
            end else begin
                send_op(rtcct_pkg::OP_CLEAR, ch, rand_dly(24'hFFFFFF));
                send_op(rtcct_pkg::OP_READ_TIME, !ch, rand_dly(24'hFFFFFF));
            end
        end
        no_idle = 1'b0;
    endtask

    // Hold the receiver off while the sender keeps offering back to back
    task automatic test_backpressure();
        no_idle       = 1'b1;
        long_hold_req = 1'b1;
        repeat (30)
            send_op(rand_op(), rand_ch(), rand_dly(24'hFFFFFF));
        no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Receiver: draw a stall per report; a pending hold-off request holds
    // the stall for a long stretch counted here.
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int unsigned pause;
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                repeat (LONG_HOLD) begin
                    @(negedge i_clk);
                    i_out_stall <= 1'b1;
                end
            end
            pause = no_idle ? 0 : $urandom_range(0, 6);
            repeat (pause) begin
                @(negedge i_clk);
                i_out_stall <= 1'b1;
            end
            @(negedge i_clk);
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    // Check every transferred report against the oldest prediction
    always @(posedge i_clk) begin : report_check
        rtcct_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            reports_seen++;
            if (reports_due.size() == 0) begin
                bad_reports++;
                if (bad_reports <= 10)
                    $display("report %0d arrived with none predicted: time %h pend %b irq %b",
                             reports_seen, o_out_data.time_now,
                             o_out_data.pending_events, o_out_data.irq);
            end else begin
                want = reports_due.pop_front();
                if (want.time_now !== o_out_data.time_now ||
                    want.pending_events !== o_out_data.pending_events ||
                    want.irq !== o_out_data.irq) begin
                    bad_reports++;
                    if (bad_reports <= 10)
                        $display("report %0d mismatch: want time %h pend %b irq %b, %s",
                                 reports_seen, want.time_now, want.pending_events, want.irq,
                                 $sformatf("got time %h pend %b irq %b",
                                           o_out_data.time_now,
                                           o_out_data.pending_events, o_out_data.irq));
                end
            end
        end
    end

    // Watchdog: drop the run once nothing has moved for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == IDLE_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d reports outstanding",
                     IDLE_LIMIT, reports_due.size());
            $display("** rtc_compare_timer_core: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_stopped_counter();
        drain_reports();
        test_compare_match();
        drain_reports();
        test_cancel_and_delays();
        drain_reports();
        test_random_sequences(items_sent + RANDOM_OPS / 2);
        test_backpressure();
        drain_reports();
        test_random_sequences(items_sent + RANDOM_OPS / 2);
        drain_reports();

        // Allow for the two-stage pipeline to show any stray report
        repeat (10) @(posedge i_clk);
        if (bad_reports == 0)
            $display("** rtc_compare_timer_core: PASSED **");
        else
            $display("** rtc_compare_timer_core: FAILED **");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/rtcct_pkg.sv
sv/rtcct_channel.sv
sv/rtc_compare_timer_core.sv
dv/rtc_compare_timer_core_test.sv
